### rtl/sle_pkg.sv
`default_nettype none

package sle_pkg;

   // Defaults for the top-level parameters
   localparam int CAPACITY_DEF     = 64;
   localparam int ELEMENT_BITS_DEF = 32;

   // Fixed field widths of the request and response beats
   localparam int FUNC_W  = 3;
   localparam int POS_W   = 7;
   localparam int VALUE_W = 32;

   typedef enum logic [FUNC_W-1:0] {
      FN_INSERT = 3'd0,
      FN_DELETE = 3'd1,
      FN_GET    = 3'd2,
      FN_LOCATE = 3'd3,
      FN_CLEAR  = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PLACE,
      ST_DONE
   } state_type;

   // One finished response, handed from the sequencer to the output register
   typedef struct packed {
      logic               status;
      logic [VALUE_W-1:0] read_value;
      logic [POS_W-1:0]   found_position;
      logic [POS_W-1:0]   list_length;
      logic               is_empty;
   } res_type;

endpackage

`default_nettype wire

### rtl/sle_mem.sv
`default_nettype none

module sle_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32,
   parameter int AW    = 6
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] store [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/sle_ctrl.sv
`default_nettype none

module sle_ctrl #(
   parameter int CAPACITY     = 64,
   parameter int ELEMENT_BITS = 32,
   parameter int AW           = 6
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [sle_pkg::FUNC_W-1:0]   req_func,
   input  wire logic [sle_pkg::POS_W-1:0]    req_position,
   input  wire logic [sle_pkg::VALUE_W-1:0]  req_value,
   input  wire logic                         out_free,
   output logic                              done,
   output sle_pkg::res_type                  res,
   output logic                              mem_we,
   output logic [AW-1:0]                     mem_waddr,
   output logic [ELEMENT_BITS-1:0]           mem_wdata,
   output logic                              mem_re,
   output logic [AW-1:0]                     mem_raddr,
   input  wire logic [ELEMENT_BITS-1:0]      mem_rdata
);

   import sle_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

   state_type              state_ff, state_in;
   func_type               op_ff, op_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [AW-1:0]          idx_ff, idx_in;
   logic [ELEMENT_BITS-1:0] val_ff, val_in;
   logic [AW-1:0]          ptr_ff, ptr_in;
   logic [AW-1:0]          end_ff, end_in;
   logic                   more_ff, more_in;
   logic                   pend_ff, pend_in;
   logic [AW-1:0]          paddr_ff, paddr_in;
   logic                   res_status_ff, res_status_in;
   logic [VALUE_W-1:0]     res_read_ff, res_read_in;
   logic [POS_W-1:0]       res_found_ff, res_found_in;

   logic [PW-1:0]  pos_w, cnt_w, idx_w, found_w;
   logic [CW-1:0]  cnt_m1;
   logic [AW-1:0]  idx, cnt_last;
   logic           ins_ok, rd_ok, accept;
   logic [63:0]    v64, rd64;

   assign pos_w    = PW'(req_position);
   assign cnt_w    = PW'(count_ff);
   assign idx_w    = pos_w - PW'(1);
   assign idx      = idx_w[AW-1:0];
   assign cnt_m1   = count_ff - CW'(1);
   assign cnt_last = cnt_m1[AW-1:0];
   assign found_w  = PW'(paddr_ff) + PW'(1);
   assign v64      = 64'(req_value);

   assign ins_ok = (pos_w != '0) && (pos_w <= cnt_w + PW'(1))
                   && (count_ff != CW'(CAPACITY));
   assign rd_ok  = (pos_w != '0) && (pos_w <= cnt_w);

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      rd64 = '0;
      rd64[ELEMENT_BITS-1:0] = mem_rdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         more_ff  <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         more_ff  <= more_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      val_ff        <= val_in;
      ptr_ff        <= ptr_in;
      end_ff        <= end_in;
      paddr_ff      <= paddr_in;
      res_status_ff <= res_status_in;
      res_read_ff   <= res_read_in;
      res_found_ff  <= res_found_in;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      val_in        = val_ff;
      ptr_in        = ptr_ff;
      end_in        = end_ff;
      more_in       = more_ff;
      pend_in       = 1'b0;
      paddr_in      = ptr_ff;
      res_status_in = res_status_ff;
      res_read_in   = res_read_ff;
      res_found_in  = res_found_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff;
      mem_wdata     = val_ff;
      mem_re        = 1'b0;
      mem_raddr     = ptr_ff;
      done          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in         = func_type'(req_func);
               idx_in        = idx;
               val_in        = v64[ELEMENT_BITS-1:0];
               res_status_in = 1'b0;
               res_read_in   = '0;
               res_found_in  = '0;
               more_in       = 1'b1;
               state_in      = ST_DONE;
               unique case (func_type'(req_func))
                  FN_INSERT: begin
                     if (!ins_ok) begin
                        res_status_in = 1'b1;
                     end else if (pos_w == cnt_w + PW'(1)) begin
                        state_in = ST_PLACE;          // append, nothing moves
                     end else begin
                        ptr_in   = cnt_last;          // walk down from the tail
                        end_in   = idx;
                        state_in = ST_SCAN;
                     end
                  end
                  FN_DELETE: begin
                     if (!rd_ok) begin
                        res_status_in = 1'b1;
                     end else if (pos_w == cnt_w) begin
                        count_in = cnt_m1;            // last entry, nothing moves
                     end else begin
                        ptr_in   = idx + AW'(1);
                        end_in   = cnt_last;
                        state_in = ST_SCAN;
                     end
                  end
                  FN_GET: begin
                     if (!rd_ok) begin
                        res_status_in = 1'b1;
                     end else begin
                        ptr_in   = idx;
                        end_in   = idx;
                        state_in = ST_SCAN;
                     end
                  end
                  FN_LOCATE: begin
                     if (count_ff != '0) begin
                        ptr_in   = '0;
                        end_in   = cnt_last;
                        state_in = ST_SCAN;
                     end
                  end
                  FN_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     res_status_in = 1'b1;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // read side: one entry per cycle until the end address is issued or a locate match stops it
            mem_re  = more_ff;
            pend_in = more_ff;
            if (more_ff) begin
               ptr_in = (op_ff == FN_INSERT) ? ptr_ff - AW'(1) : ptr_ff + AW'(1);
               if (ptr_ff == end_ff) begin
                  more_in = 1'b0;
               end
            end
            // data side: entry read last cycle
            if (pend_ff) begin
               case (op_ff)
                  FN_INSERT: begin
                     mem_we    = 1'b1;
                     mem_waddr = paddr_ff + AW'(1);
                     mem_wdata = mem_rdata;
                     if (!more_ff) begin
                        state_in = ST_PLACE;
                     end
                  end
                  FN_DELETE: begin
                     mem_we    = 1'b1;
                     mem_waddr = paddr_ff - AW'(1);
                     mem_wdata = mem_rdata;
                     if (!more_ff) begin
                        count_in = cnt_m1;
                        state_in = ST_DONE;
                     end
                  end
                  FN_GET: begin
                     res_read_in = rd64[VALUE_W-1:0];
                     state_in    = ST_DONE;
                  end
                  FN_LOCATE: begin
                     if (mem_rdata == val_ff) begin
                        res_found_in = found_w[POS_W-1:0];
                        more_in      = 1'b0;
                        state_in     = ST_DONE;
                     end else if (!more_ff) begin
                        state_in = ST_DONE;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_PLACE: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = val_ff;
            count_in  = count_ff + CW'(1);
            state_in  = ST_DONE;
         end

         ST_DONE: begin
            done = 1'b1;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      res.status         = res_status_ff;
      res.read_value     = res_read_ff;
      res.found_position = res_found_ff;
      res.list_length    = cnt_w[POS_W-1:0];
      res.is_empty       = (count_ff == '0);
   end

endmodule

`default_nettype wire

### rtl/sequential_list_engine_top.sv
// Requests: insert moves the entries from the position on, none when
//   appending; delete moves the entries after it, none for the last entry;
//   locate reads entries until a match; clear, rejects, empty locate touch none.
// Throughput: one request in flight; the move or search walks the element
//   memory one entry per cycle.
// Reset: synchronous, active high; empties the list, drops any pending beat.
`default_nettype none

module sequential_list_engine_top #(
   parameter int CAPACITY     = sle_pkg::CAPACITY_DEF,
   parameter int ELEMENT_BITS = sle_pkg::ELEMENT_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request channel
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [sle_pkg::FUNC_W-1:0]   req_func,
   input  wire logic [sle_pkg::POS_W-1:0]    req_position,
   input  wire logic [sle_pkg::VALUE_W-1:0]  req_value,
   // response channel
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_status,
   output logic [sle_pkg::VALUE_W-1:0]       rsp_read_value,
   output logic [sle_pkg::POS_W-1:0]         rsp_found_position,
   output logic [sle_pkg::POS_W-1:0]         rsp_list_length,
   output logic                              rsp_is_empty
);

   import sle_pkg::*;

   localparam int AW = $clog2(CAPACITY);

   logic                    done;
   logic                    out_free;
   res_type                 res;
   logic                    mem_we, mem_re;
   logic [AW-1:0]           mem_waddr, mem_raddr;
   logic [ELEMENT_BITS-1:0] mem_wdata, mem_rdata;

   logic    rsp_valid_ff, rsp_valid_in;
   res_type rsp_res_ff;

   // Output register: free when empty or when its beat leaves this cycle,
   // so the sequencer can hand over a new response while the last one drains.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done && out_free) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_res_ff.status;
   assign rsp_read_value     = rsp_res_ff.read_value;
   assign rsp_found_position = rsp_res_ff.found_position;
   assign rsp_list_length    = rsp_res_ff.list_length;
   assign rsp_is_empty       = rsp_res_ff.is_empty;

   // Sequencer: decodes the request, walks the memory, builds the response.
   sle_ctrl #(
      .CAPACITY     (CAPACITY),
      .ELEMENT_BITS (ELEMENT_BITS),
      .AW           (AW)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_func     (req_func),
      .req_position (req_position),
      .req_value    (req_value),
      .out_free     (out_free),
      .done         (done),
      .res          (res),
      .mem_we       (mem_we),
      .mem_waddr    (mem_waddr),
      .mem_wdata    (mem_wdata),
      .mem_re       (mem_re),
      .mem_raddr    (mem_raddr),
      .mem_rdata    (mem_rdata)
   );

   // Element memory: one write and one registered read per cycle.
   // Moves read one entry and write its neighbor in the following cycle; the read
   // pointer runs away from the write, so no bypass is needed.
   sle_mem #(
      .DEPTH (CAPACITY),
      .WIDTH (ELEMENT_BITS),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

endmodule

`default_nettype wire

### rtl/sle_chk.sv
`default_nettype none

module sle_chk (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic                         rsp_status,
   input wire logic [sle_pkg::VALUE_W-1:0]  rsp_read_value,
   input wire logic [sle_pkg::POS_W-1:0]    rsp_found_position,
   input wire logic [sle_pkg::POS_W-1:0]    rsp_list_length,
   input wire logic                         rsp_is_empty
);

   // stalled beat holds valid, read value, found position and length
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_value)
         && $stable(rsp_found_position) && $stable(rsp_list_length))
      else $error("response beat changed while stalled");

   a_empty_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_list_length == '0)
      else $error("empty flag with nonzero length");

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_read_value == '0 && rsp_found_position == '0)
      else $error("error response carries data");

   a_found_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found_position != '0 |-> !rsp_is_empty && !rsp_status)
      else $error("match reported in empty list");

endmodule

bind sequential_list_engine_top sle_chk u_sle_chk (.*);

`default_nettype wire
